/* hdl/resource_container_encoder_assert.svh */
// Assertion macros used by the resource container encoder checker.
// Needs signals named clock and reset in the scope where the macros are used.
`ifndef RESOURCE_CONTAINER_ENCODER_ASSERT_SVH
`define RESOURCE_CONTAINER_ENCODER_ASSERT_SVH

// same-cycle implication, idle while in reset
`define RCE_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rce: same-cycle check failed");

// next-cycle implication, idle while in reset
`define RCE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rce: next-cycle check failed");

`endif

/* hdl/rce_pkg.sv */
// Types, constants and the microcode table of the resource container encoder.
// No dependencies.
package rce_pkg;

   // item opcodes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_HEADER = 2'd1;
   localparam logic [1:0] OP_DATA   = 2'd2;
   localparam logic [1:0] OP_FINISH = 2'd3;

   localparam logic [22:0] MAX_LEN      = 23'd4210688;
   localparam logic [22:0] LONG_MIN_LEN = 23'd16385;
   localparam logic [7:0]  TYPE_STEP    = 8'h3f;
   localparam logic [15:0] ID_STEP      = 16'h3fff;
   localparam logic [7:0]  SIG_BYTE1    = 8'h45;
   localparam logic [7:0]  SIG_BYTE2    = 8'h47;
   localparam logic [7:0]  TERM_BYTE    = 8'h00;
   localparam logic [7:0]  ID_FULL_HI   = 8'h7f;
   localparam logic [7:0]  ID_FULL_LO   = 8'hff;

   // microcode addresses
   localparam logic [3:0] UA_START  = 4'd0;
   localparam logic [3:0] UA_SIG1   = 4'd1;
   localparam logic [3:0] UA_SIG2   = 4'd2;
   localparam logic [3:0] UA_SIG3   = 4'd3;
   localparam logic [3:0] UA_DATA   = 4'd4;
   localparam logic [3:0] UA_FIN    = 4'd5;
   localparam logic [3:0] UA_ERR    = 4'd6;
   localparam logic [3:0] UA_TYPE   = 4'd7;
   localparam logic [3:0] UA_IDHI   = 4'd8;
   localparam logic [3:0] UA_IDLO   = 4'd9;
   localparam logic [3:0] UA_LENHI  = 4'd10;
   localparam logic [3:0] UA_LENMID = 4'd11;
   localparam logic [3:0] UA_LENLO  = 4'd12;

   typedef enum logic [3:0] {
      SRC_ZERO, SRC_SIG1, SRC_SIG2, SRC_DATA, SRC_TYPE,
      SRC_IDHI, SRC_IDLO, SRC_LEN2, SRC_LEN1, SRC_LEN0
   } src_type;

   typedef enum logic [1:0] {
      COND_NONE, COND_DT_ZERO, COND_DI_ZERO, COND_LEN_SHORT
   } cond_type;

   // one control word per step: skip without output when cond holds,
   // otherwise emit src and go to next
   typedef struct packed {
      src_type    src;
      cond_type   cond;
      logic [3:0] skip_to;
      logic [3:0] next;
      logic       last;
      logic       done;
      logic       err;
   } uword_type;

   function automatic uword_type rce_ucode(input logic [3:0] addr);
      uword_type w;
      w = '{src: SRC_ZERO, cond: COND_NONE, skip_to: UA_ERR, next: UA_ERR,
            last: 1'b1, done: 1'b1, err: 1'b1};
      unique case (addr)
         UA_START:  w = '{SRC_ZERO, COND_NONE, UA_START, UA_SIG1, 1'b0, 1'b0, 1'b0};
         UA_SIG1:   w = '{SRC_SIG1, COND_NONE, UA_SIG1, UA_SIG2, 1'b0, 1'b0, 1'b0};
         UA_SIG2:   w = '{SRC_SIG2, COND_NONE, UA_SIG2, UA_SIG3, 1'b0, 1'b0, 1'b0};
         UA_SIG3:   w = '{SRC_SIG2, COND_NONE, UA_SIG3, UA_SIG3, 1'b1, 1'b1, 1'b0};
         UA_DATA:   w = '{SRC_DATA, COND_NONE, UA_DATA, UA_DATA, 1'b1, 1'b1, 1'b0};
         UA_FIN:    w = '{SRC_ZERO, COND_NONE, UA_FIN, UA_FIN, 1'b1, 1'b1, 1'b0};
         UA_TYPE:   w = '{SRC_TYPE, COND_DT_ZERO, UA_IDHI, UA_TYPE, 1'b0, 1'b0, 1'b0};
         UA_IDHI:   w = '{SRC_IDHI, COND_DI_ZERO, UA_LENHI, UA_IDLO, 1'b0, 1'b0, 1'b0};
         UA_IDLO:   w = '{SRC_IDLO, COND_NONE, UA_IDLO, UA_IDHI, 1'b0, 1'b0, 1'b0};
         UA_LENHI:  w = '{SRC_LEN2, COND_LEN_SHORT, UA_LENMID, UA_LENMID, 1'b0, 1'b0, 1'b0};
         UA_LENMID: w = '{SRC_LEN1, COND_NONE, UA_LENMID, UA_LENLO, 1'b0, 1'b0, 1'b0};
         UA_LENLO:  w = '{SRC_LEN0, COND_NONE, UA_LENLO, UA_LENLO, 1'b1, 1'b1, 1'b0};
         default:   w = '{SRC_ZERO, COND_NONE, UA_ERR, UA_ERR, 1'b1, 1'b1, 1'b1};
      endcase
      return w;
   endfunction

endpackage

/* hdl/resource_container_encoder.sv */
// Resource container encoder top level: header checks, microcode sequencer, byte output.
// Depends on rce_pkg.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+------------------------------------------------
//   req     | in  | req_valid/req_stall | opcode, res_type, res_id, payload_length, data_byte
//   rsp     | out | rsp_valid/rsp_stall | out_byte, last, error
//
// Payload, finish and error items go straight to the output register: one item per cycle
// while req_stall is low. A start runs 4 steps, a header one step per byte (up to 18) and
// up to 3 skipped steps; the sequencer runs one step per unstalled cycle, one byte at most.
// Reset is synchronous, active high: type 1, next id 1, failure clear, no output pending.
// A stalled output freezes the sequencer; req_stall is high while a sequence runs or the
// output register holds an item that is not being taken.
module resource_container_encoder
   import rce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_res_type,
   input  logic [15:0] req_res_id,
   input  logic [22:0] req_payload_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_error
);

   // stream state
   logic [7:0]  cur_type_ff, cur_type_in;
   logic [16:0] next_id_ff, next_id_in;
   logic        failed_ff, failed_in;

   // sequencer
   logic        busy_ff, busy_in;
   logic [3:0]  pc_ff, pc_in;
   uword_type   uw;

   // header operands held for the sequence
   logic [7:0]  dt_ff, dt_in;     // remaining type advance
   logic [15:0] di_ff, di_in;     // remaining id advance
   logic [23:0] lw_ff, lw_in;     // length code, bit 23 set for the 3-byte form

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_error_ff, rsp_error_in;

   logic        adv, accept, skip;
   logic        type_lt, type_gt, id_lt, len_big, hdr_err, len_long;
   logic [16:0] base_id;
   logic [22:0] len_lrem, len_srem;
   logic        dt_ge, di_ge;
   logic [7:0]  src_byte;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy_ff || !adv;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_error    = rsp_error_ff;

   // header checks, all done in the accept cycle
   assign type_lt  = req_res_type < cur_type_ff;
   assign type_gt  = req_res_type > cur_type_ff;
   assign base_id  = type_gt ? 17'd1 : next_id_ff;   // a type advance restarts ids at 1
   assign id_lt    = {1'b0, req_res_id} < base_id;
   assign len_big  = req_payload_length > MAX_LEN;
   assign hdr_err  = type_lt || id_lt || len_big;
   assign len_long = req_payload_length >= LONG_MIN_LEN;
   assign len_lrem = req_payload_length - LONG_MIN_LEN;
   assign len_srem = req_payload_length - 23'd1;

   assign uw    = rce_ucode(pc_ff);
   assign dt_ge = dt_ff >= TYPE_STEP;
   assign di_ge = di_ff >= ID_STEP;

   always_comb begin
      unique case (uw.cond)
         COND_NONE:      skip = 1'b0;
         COND_DT_ZERO:   skip = (dt_ff == 8'd0);
         COND_DI_ZERO:   skip = (di_ff == 16'd0);
         COND_LEN_SHORT: skip = !lw_ff[23];
         default:        skip = 1'b0;
      endcase
   end

   // byte selected by the current control word
   always_comb begin
      unique case (uw.src)
         SRC_ZERO: src_byte = TERM_BYTE;
         SRC_SIG1: src_byte = SIG_BYTE1;
         SRC_SIG2: src_byte = SIG_BYTE2;
         SRC_DATA: src_byte = rsp_byte_ff;  // not used by the program; data goes direct
         SRC_TYPE: src_byte = dt_ge ? TYPE_STEP : dt_ff;
         SRC_IDHI: src_byte = di_ge ? ID_FULL_HI : {2'b01, di_ff[13:8]};
         SRC_IDLO: src_byte = di_ge ? ID_FULL_LO : di_ff[7:0];
         SRC_LEN2: src_byte = lw_ff[23:16];
         SRC_LEN1: src_byte = lw_ff[15:8];
         SRC_LEN0: src_byte = lw_ff[7:0];
         default:  src_byte = TERM_BYTE;
      endcase
   end

   always_comb begin
      cur_type_in  = cur_type_ff;
      next_id_in   = next_id_ff;
      failed_in    = failed_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      dt_in        = dt_ff;
      di_in        = di_ff;
      lw_in        = lw_ff;
      rsp_valid_in = adv ? 1'b0 : rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;

      if (accept) begin
         if (req_opcode == OP_START) begin
            cur_type_in = 8'd1;
            next_id_in  = 17'd1;
            failed_in   = 1'b0;
            busy_in     = 1'b1;
            pc_in       = UA_START;
         end else if (failed_ff) begin
            // sticky failure: every item gives one error result
            rsp_valid_in = 1'b1;
            rsp_byte_in  = TERM_BYTE;
            rsp_last_in  = 1'b1;
            rsp_error_in = 1'b1;
         end else begin
            unique case (req_opcode)
               OP_DATA: begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = req_data_byte;
                  rsp_last_in  = 1'b1;
                  rsp_error_in = 1'b0;
               end
               OP_FINISH: begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = TERM_BYTE;
                  rsp_last_in  = 1'b1;
                  rsp_error_in = 1'b0;
               end
               OP_HEADER: begin
                  // zero length: skipped entirely
                  if (req_payload_length != 23'd0) begin
                     if (hdr_err) begin
                        failed_in    = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_byte_in  = TERM_BYTE;
                        rsp_last_in  = 1'b1;
                        rsp_error_in = 1'b1;
                     end else begin
                        dt_in       = type_gt ? (req_res_type - cur_type_ff) : 8'd0;
                        di_in       = req_res_id - base_id[15:0];
                        lw_in       = len_long ? {2'b11, len_lrem[21:0]}
                                               : {8'h00, 2'b10, len_srem[13:0]};
                        cur_type_in = req_res_type;
                        next_id_in  = {1'b0, req_res_id} + 17'd1;
                        busy_in     = 1'b1;
                        pc_in       = UA_TYPE;
                     end
                  end
               end
               default: begin
                  // start handled above
               end
            endcase
         end
      end else if (busy_ff && adv) begin
         if (skip) begin
            pc_in = uw.skip_to;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = src_byte;
            rsp_last_in  = uw.last;
            rsp_error_in = uw.err;
            pc_in        = uw.next;
            busy_in      = !uw.done;
            if (uw.src == SRC_TYPE) begin
               dt_in = dt_ge ? (dt_ff - TYPE_STEP) : 8'd0;
            end
            if (uw.src == SRC_IDLO) begin
               di_in = di_ge ? (di_ff - ID_STEP) : 16'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_type_ff  <= 8'd1;
         next_id_ff   <= 17'd1;
         failed_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         pc_ff        <= UA_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_type_ff  <= cur_type_in;
         next_id_ff   <= next_id_in;
         failed_ff    <= failed_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      di_ff        <= di_in;
      lw_ff        <= lw_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

endmodule

/* hdl/rce_checker.sv */
// Port-level checks for the resource container encoder, bound to the top level.
// Depends on rce_pkg and resource_container_encoder_assert.svh.
`include "resource_container_encoder_assert.svh"

module rce_checker
   import rce_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last,
   input logic        rsp_error
);

   // an error item is a lone zero byte closing its item
   `RCE_ASSERT_IMPL(a_err_shape, rsp_valid && rsp_error, rsp_last && (rsp_out_byte == 8'h00))

   // no new item while an item's bytes are still coming out
   `RCE_ASSERT_IMPL(a_no_accept_midframe, rsp_valid && !rsp_last, req_stall)

   // after an accepted start, req_stall is high: the signature sequence is running
   `RCE_ASSERT_NEXT(a_start_busy, req_valid && !req_stall && (req_opcode == OP_START), req_stall)

   `RCE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last)
                    && $stable(rsp_error))

endmodule

bind resource_container_encoder rce_checker u_rce_checker (.*);
